### hdl/pmms_pkg.sv
package pmms_pkg;

   localparam int NUM_CHANNELS = 64;
   localparam int DATA_W = 32;
   localparam int CH_FIELD_W = 8;
   localparam int CFG_W = 7;
   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int LIMIT_W = CH_FIELD_W + 1;
   localparam int DIV_CNT_W = $clog2(DATA_W);

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);
   localparam logic [LIMIT_W-1:0] CH_LIMIT = LIMIT_W'(NUM_CHANNELS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(DATA_W - 1);

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_DRAIN  = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] last_value;
      logic [DATA_W-1:0] last_stamp;
      logic [DATA_W-1:0] sum;
      logic [DATA_W-1:0] count;
      logic [DATA_W-1:0] min;
      logic [DATA_W-1:0] max;
      logic [DATA_W-1:0] avg;
   } entry_type;

   typedef struct packed {
      logic                     in_range;
      logic signed [DATA_W-1:0] average;
      logic signed [DATA_W-1:0] minimum;
      logic signed [DATA_W-1:0] maximum;
      logic [DATA_W-1:0]        sample_count;
      logic signed [DATA_W-1:0] latest_sample;
      logic signed [DATA_W-1:0] latest_time;
   } rsp_type;

endpackage

### hdl/pmms_ifs.sv
interface pmms_req_if import pmms_pkg::*; ();
   logic                     valid;
   logic                     ready;
   op_type                   op;
   logic [CH_FIELD_W-1:0]    channel;
   logic signed [DATA_W-1:0] sample;
   logic signed [DATA_W-1:0] sample_time;

   modport source (output valid, op, channel, sample, sample_time, input ready);
   modport sink (input valid, op, channel, sample, sample_time, output ready);
endinterface

interface pmms_rsp_if import pmms_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     in_range;
   logic signed [DATA_W-1:0] average;
   logic signed [DATA_W-1:0] minimum;
   logic signed [DATA_W-1:0] maximum;
   logic [DATA_W-1:0]        sample_count;
   logic signed [DATA_W-1:0] latest_sample;
   logic signed [DATA_W-1:0] latest_time;

   modport source (output valid, in_range, average, minimum, maximum, sample_count,
                   latest_sample, latest_time, input ready);
   modport sink (input valid, in_range, average, minimum, maximum, sample_count,
                 latest_sample, latest_time, output ready);
endinterface

### hdl/per_channel_min_max_mean_stats.sv
// Statistics table with one entry per channel, held in a single synchronous memory.
// The req_ch channel takes one word at a time: an update adds a sample to a channel's
// window, a drain reads the channel's average, min, max, count and latest sample, then
// clears the window. Only drains produce a word on the rsp_ch channel; an update or
// drain with a channel at or above channels_in_use (capped at 64) leaves the table
// unchanged; such a drain returns a word with in_range low and all other fields zero.
// An update does one memory read, then the modified entry is written back.
// A drain of a non-empty window reads the entry, then runs the 32-step shift-subtract
// divider; an empty window skips the divider and an out-of-range drain the memory read.
// The result sits in an output register. While it waits, the block takes and processes
// further items; a drain that finishes before that word is taken waits for it.
// csr_wr_en writes channels_in_use, which resets to 64.
// Reset clears the per-entry valid bits, so every channel reads as zero until written.
module per_channel_min_max_mean_stats import pmms_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   pmms_req_if.sink         req_ch,
   pmms_rsp_if.source       rsp_ch,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   entry_type             mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] valid_ff;
   entry_type             rd_data_ff;
   logic                  rd_valid_ff;

   logic [CFG_W-1:0]      cfg_ff;
   state_type             state_ff, state_in;
   op_type                op_ff;
   logic [CH_W-1:0]       ch_ff;
   logic                  ok_ff;
   logic [DATA_W-1:0]     sample_ff;
   logic [DATA_W-1:0]     time_ff;
   logic                  use_kept_ff, use_kept_in;

   logic [DATA_W-1:0]     div_rem_ff, div_rem_in;
   logic [DATA_W-1:0]     div_q_ff, div_q_in;
   logic [DATA_W-1:0]     divisor_ff, divisor_in;
   logic                  div_neg_ff, div_neg_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  ch_ok;
   logic [LIMIT_W-1:0]    limit;
   logic                  rd_en;
   logic                  wr_en;
   entry_type             wr_data;
   entry_type             ent;
   entry_type             upd;
   logic                  out_free;
   logic [DATA_W:0]       trial;
   logic [DATA_W-1:0]     avg_div;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept = req_ch.valid && req_ch.ready;
   assign limit = ({2'b00, cfg_ff} > CH_LIMIT) ? CH_LIMIT : {2'b00, cfg_ff};
   assign ch_ok = {1'b0, req_ch.channel} < limit;
   assign ent = rd_valid_ff ? rd_data_ff : '0;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign trial = {div_rem_ff, div_q_ff[DATA_W-1]};
   assign avg_div = div_neg_ff ? (DATA_W'(0) - div_q_ff) : div_q_ff;

   always_comb begin
      upd = ent;
      upd.last_value = sample_ff;
      upd.last_stamp = time_ff;
      upd.sum = ent.sum + sample_ff;
      upd.count = ent.count + DATA_W'(1);
      if (upd.count == DATA_W'(1)) begin
         upd.min = sample_ff;
         upd.max = sample_ff;
      end else begin
         if ($signed(sample_ff) < $signed(ent.min)) begin
            upd.min = sample_ff;
         end
         if ($signed(sample_ff) > $signed(ent.max)) begin
            upd.max = sample_ff;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      use_kept_in = use_kept_ff;
      div_rem_in = div_rem_ff;
      div_q_in = div_q_ff;
      divisor_in = divisor_ff;
      div_neg_in = div_neg_ff;
      div_cnt_in = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in = rsp_data_ff;
      rd_en = 1'b0;
      wr_en = 1'b0;
      wr_data = upd;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (ch_ok) begin
                  rd_en = 1'b1;
                  state_in = ST_READ;
               end else if (req_ch.op == OP_DRAIN) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            if (op_ff == OP_UPDATE) begin
               wr_en = 1'b1;
               wr_data = upd;
               state_in = ST_IDLE;
            end else if (ent.count == '0) begin
               use_kept_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               use_kept_in = 1'b0;
               div_neg_in = ent.sum[DATA_W-1];
               div_q_in = ent.sum[DATA_W-1] ? (DATA_W'(0) - ent.sum) : ent.sum;
               div_rem_in = '0;
               divisor_in = ent.count;
               div_cnt_in = DIV_LAST_STEP;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (trial >= {1'b0, divisor_ff}) begin
               div_rem_in = DATA_W'(trial - {1'b0, divisor_ff});
               div_q_in = {div_q_ff[DATA_W-2:0], 1'b1};
            end else begin
               div_rem_in = trial[DATA_W-1:0];
               div_q_in = {div_q_ff[DATA_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            if (div_cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '0;
               if (ok_ff) begin
                  rsp_data_in.in_range = 1'b1;
                  rsp_data_in.average = use_kept_ff ? ent.avg : avg_div;
                  rsp_data_in.minimum = ent.min;
                  rsp_data_in.maximum = ent.max;
                  rsp_data_in.sample_count = ent.count;
                  rsp_data_in.latest_sample = ent.last_value;
                  rsp_data_in.latest_time = ent.last_stamp;
                  wr_en = 1'b1;
                  wr_data = '0;
                  wr_data.last_value = ent.last_value;
                  wr_data.last_stamp = ent.last_stamp;
                  wr_data.avg = use_kept_ff ? ent.avg : avg_div;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ch_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[req_ch.channel[CH_W-1:0]];
         rd_valid_ff <= valid_ff[req_ch.channel[CH_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cfg_ff <= CFG_RESET;
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[ch_ff] <= 1'b1;
         end
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_ch.op;
         ch_ff <= req_ch.channel[CH_W-1:0];
         ok_ff <= ch_ok;
         sample_ff <= req_ch.sample;
         time_ff <= req_ch.sample_time;
      end
      use_kept_ff <= use_kept_in;
      div_rem_ff <= div_rem_in;
      div_q_ff <= div_q_in;
      divisor_ff <= divisor_in;
      div_neg_ff <= div_neg_in;
      div_cnt_ff <= div_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.in_range = rsp_data_ff.in_range;
   assign rsp_ch.average = rsp_data_ff.average;
   assign rsp_ch.minimum = rsp_data_ff.minimum;
   assign rsp_ch.maximum = rsp_data_ff.maximum;
   assign rsp_ch.sample_count = rsp_data_ff.sample_count;
   assign rsp_ch.latest_sample = rsp_data_ff.latest_sample;
   assign rsp_ch.latest_time = rsp_data_ff.latest_time;

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_cnt_ff == '0) |=> state_ff == ST_DONE)
      else $error("divider did not hand over to the result state");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_DIV) |-> !accept)
      else $error("a word was taken while an entry was in flight");

   a_rsp_from_drain: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff ##1 rsp_valid_ff) |-> $past(op_ff == OP_DRAIN))
      else $error("a result appeared for an update");

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.in_range) |->
         (rsp_data_ff.average == '0 && rsp_data_ff.sample_count == '0))
      else $error("out-of-range drain returned nonzero fields");

endmodule

### verif/pmms_stats_checker.sv
module pmms_stats_checker import pmms_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   pmms_req_if              req_mon,
   pmms_rsp_if              rsp_mon,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   output int               fail_count,
   output int               pending_words,
   output int               checked_words
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [DATA_W-1:0] last_value [NUM_CHANNELS];
   logic [DATA_W-1:0] last_stamp [NUM_CHANNELS];
   logic [DATA_W-1:0] win_sum    [NUM_CHANNELS];
   logic [DATA_W-1:0] win_count  [NUM_CHANNELS];
   logic [DATA_W-1:0] win_min    [NUM_CHANNELS];
   logic [DATA_W-1:0] win_max    [NUM_CHANNELS];
   logic [DATA_W-1:0] kept_avg   [NUM_CHANNELS];
   logic [CFG_W-1:0]  chan_cfg;
   rsp_type           report_q [$];
   int                fails = 0;
   int                checked = 0;

   assign fail_count = fails;
   assign checked_words = checked;

   function automatic bit channel_active(logic [CH_FIELD_W-1:0] ch);
      int lim;
      lim = (int'(chan_cfg) > NUM_CHANNELS) ? NUM_CHANNELS : int'(chan_cfg);
      return int'(ch) < lim;
   endfunction

   function automatic void add_sample(int idx, logic [DATA_W-1:0] smp,
                                      logic [DATA_W-1:0] stamp);
      last_value[idx] = smp;
      last_stamp[idx] = stamp;
      win_sum[idx] = win_sum[idx] + smp;
      win_count[idx] = win_count[idx] + 1;
      if (win_count[idx] == 1) begin
         win_min[idx] = smp;
         win_max[idx] = smp;
      end else begin
         if ($signed(smp) < $signed(win_min[idx])) win_min[idx] = smp;
         if ($signed(smp) > $signed(win_max[idx])) win_max[idx] = smp;
      end
   endfunction

   function automatic rsp_type close_window(logic [CH_FIELD_W-1:0] ch);
      rsp_type rpt;
      longint  quotient;
      int      idx;
      rpt = '0;
      if (!channel_active(ch)) return rpt;
      idx = int'(ch);
      if (win_count[idx] != 0) begin
         quotient = longint'($signed(win_sum[idx])) / longint'({32'd0, win_count[idx]});
         kept_avg[idx] = quotient[DATA_W-1:0];
      end
      rpt.in_range = 1'b1;
      rpt.average = kept_avg[idx];
      rpt.minimum = win_min[idx];
      rpt.maximum = win_max[idx];
      rpt.sample_count = win_count[idx];
      rpt.latest_sample = last_value[idx];
      rpt.latest_time = last_stamp[idx];
      win_sum[idx] = '0;
      win_count[idx] = '0;
      win_min[idx] = '0;
      win_max[idx] = '0;
      return rpt;
   endfunction

   function automatic void compare_field(string name, logic [DATA_W-1:0] want,
                                         logic [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fails++;
      end
   endfunction

   function automatic void check_report();
      rsp_type want;
      if (report_q.size() == 0) begin
         $display("%0t: result word with no drain waiting, expected none, actual average %0h",
                  $time, rsp_mon.average);
         fails++;
         return;
      end
      want = report_q.pop_front();
      compare_field("in_range", DATA_W'(want.in_range), DATA_W'(rsp_mon.in_range));
      compare_field("average", want.average, rsp_mon.average);
      compare_field("minimum", want.minimum, rsp_mon.minimum);
      compare_field("maximum", want.maximum, rsp_mon.maximum);
      compare_field("sample_count", want.sample_count, rsp_mon.sample_count);
      compare_field("latest_sample", want.latest_sample, rsp_mon.latest_sample);
      compare_field("latest_time", want.latest_time, rsp_mon.latest_time);
      checked++;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         chan_cfg = CFG_RESET;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            last_value[i] = '0;
            last_stamp[i] = '0;
            win_sum[i] = '0;
            win_count[i] = '0;
            win_min[i] = '0;
            win_max[i] = '0;
            kept_avg[i] = '0;
         end
         report_q.delete();
      end else begin
         if (csr_wr_en) chan_cfg = csr_wr_data;
         if (rsp_mon.valid && rsp_mon.ready) check_report();
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.op == OP_UPDATE) begin
               if (channel_active(req_mon.channel))
                  add_sample(int'(req_mon.channel), req_mon.sample, req_mon.sample_time);
            end else begin
               report_q.push_back(close_window(req_mon.channel));
            end
         end
      end
      pending_words <= report_q.size();
   end

endmodule

### verif/tb_per_channel_min_max_mean_stats.sv
module tb_per_channel_min_max_mean_stats;
   timeunit 1ns;
   timeprecision 1ps;
   import pmms_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 50;
   localparam int LONG_HOLD_CYCLES = 300;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;
   int               fail_count;
   int               pending_words;
   int               checked_words;
   int               cycle_count = 0;
   int               words_sent = 0;
   int               drains_sent = 0;
   int               settings_used = 0;
   int               chan_limit = NUM_CHANNELS;
   bit               idle_en = 1'b1;
   bit               long_hold_req = 1'b0;

   pmms_req_if req_ch();
   pmms_rsp_if rsp_ch();

   per_channel_min_max_mean_stats u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pmms_stats_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .checked_words (checked_words)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("per_channel_min_max_mean_stats verification failed");
         $finish;
      end
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else if (idle_en && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic logic [CH_FIELD_W-1:0] pick_channel();
      int roll;
      int hot;
      roll = $urandom_range(0, 99);
      hot = (chan_limit < 6) ? chan_limit : 6;
      if (chan_limit == 0 || roll < 12) return CH_FIELD_W'($urandom_range(0, 255));
      if (roll < 18) return CH_FIELD_W'(chan_limit);
      if (roll < 65) return CH_FIELD_W'($urandom_range(0, hot - 1));
      return CH_FIELD_W'($urandom_range(0, chan_limit - 1));
   endfunction

   function automatic logic [DATA_W-1:0] pick_sample();
      logic [DATA_W-1:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom_range(0, 200) - 100;
         1: begin
            case ($urandom_range(0, 3))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = '0;
               default: v = '1;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_word(input bit drain, input logic [CH_FIELD_W-1:0] ch,
                            input logic [DATA_W-1:0] smp, input logic [DATA_W-1:0] stamp);
      if (idle_en && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         req_ch.sample <= $urandom;
         req_ch.channel <= CH_FIELD_W'($urandom);
         repeat ($urandom_range(0, 8)) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.op <= drain ? OP_DRAIN : OP_UPDATE;
      req_ch.channel <= ch;
      req_ch.sample <= smp;
      req_ch.sample_time <= stamp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
      if (drain) drains_sent++;
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_words != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_setting(input int value);
      wait_quiet();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= CFG_W'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      chan_limit = (value > NUM_CHANNELS) ? NUM_CHANNELS : value;
      settings_used++;
   endtask

   task automatic random_words(input int count);
      for (int n = 0; n < count; n++)
         send_word($urandom_range(0, 4) == 0, pick_channel(), pick_sample(), $urandom);
   endtask

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.op <= OP_UPDATE;
      req_ch.channel <= '0;
      req_ch.sample <= '0;
      req_ch.sample_time <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      reset <= 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      send_word(1'b1, 8'd0, '0, '0);
      send_word(1'b0, 8'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_word(1'b0, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_word(1'b0, 8'd0, 32'h8000_0000, 32'hFFFF_FFFF);
      send_word(1'b1, 8'd0, '0, '0);
      send_word(1'b1, 8'd0, '1, '1);
      send_word(1'b0, 8'd63, -7, 5);
      send_word(1'b0, 8'd63, 2, 6);
      send_word(1'b0, 8'd63, -9, 7);
      send_word(1'b1, 8'd63, '0, '0);
      send_word(1'b0, 8'd64, 5, 5);
      send_word(1'b1, 8'd64, '0, '0);
      send_word(1'b0, 8'd255, '1, '1);
      send_word(1'b1, 8'd255, '1, '1);
      send_word(1'b0, 8'd1, -1, -1);
      send_word(1'b1, 8'd1, '0, '0);
      send_word(1'b0, 8'd2, '0, '0);
      send_word(1'b0, 8'd2, 32'h5555_5555, 32'hAAAA_AAAA);
      send_word(1'b1, 8'd2, '0, '0);
      send_word(1'b1, 8'd2, '0, '0);

      write_setting(1);
      random_words(80);
      write_setting(0);
      random_words(20);
      write_setting(127);
      random_words(70);
      long_hold_req = 1'b1;
      for (int n = 0; n < 12; n++)
         send_word(n % 3 != 0, CH_FIELD_W'(n % 4), pick_sample(), $urandom);
      random_words(70);
      write_setting($urandom_range(2, 126));
      random_words(150);
      write_setting(63);
      random_words(100);
      write_setting(64);
      idle_en = 1'b0;
      random_words(150);
      wait_quiet();

      $display("Sent %0d request words (%0d drains) under %0d register settings; %0d results checked.",
               words_sent, drains_sent, settings_used, checked_words);
      $display("Run included sum wrap, empty and out-of-range drains, a long result stall "
               , "and idle-free streaming.");
      if (fail_count == 0) begin
         $display("per_channel_min_max_mean_stats verification clean");
      end else begin
         $display("per_channel_min_max_mean_stats verification failed");
      end
      $finish;
   end

endmodule
